[src/deq_pkg.sv]
// Shared types, constants and helpers for the double-ended queue.
// Used by deq_cell and double_ended_queue_unit; depends on nothing else.
package deq_pkg;

   localparam int DEPTH      = 1024;
   localparam int ELEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef logic [ELEM_WIDTH-1:0] deq_elem_type;
   typedef logic [IDX_W-1:0]      deq_idx_type;
   typedef logic [CNT_W-1:0]      deq_cnt_type;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_ASSIGN_AT  = 3'd5,
      OP_INSERT_AT  = 3'd6
   } deq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } deq_status_type;

   // Commands broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_REMOVE = 3'd2,
      CELL_WRITE  = 3'd3,
      CELL_READ   = 3'd4
   } deq_cell_op_type;

   typedef struct packed {
      deq_cell_op_type op;
      deq_idx_type     idx;
      deq_elem_type    data;
   } deq_cmd_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] elem_data;
      logic [9:0]  position;
   } deq_req_type;

   typedef struct packed {
      logic [31:0]    result_data;
      deq_status_type status;
      logic [10:0]    count;
      logic           is_empty;
   } deq_rsp_type;

   function automatic deq_elem_type to_elem(input logic [31:0] d);
      logic [ELEM_WIDTH+31:0] wide;
      wide = {{ELEM_WIDTH{1'b0}}, d};
      return wide[ELEM_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] from_elem(input deq_elem_type e);
      logic [ELEM_WIDTH+31:0] wide;
      wide = {32'd0, e};
      return wide[31:0];
   endfunction

   function automatic deq_idx_type pos_to_idx(input logic [9:0] p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[IDX_W-1:0];
   endfunction

   function automatic deq_idx_type cnt_to_idx(input deq_cnt_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[IDX_W-1:0];
   endfunction

   function automatic logic [10:0] cnt_to_field(input deq_cnt_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[10:0];
   endfunction

endpackage

[src/double_ended_queue_unit.sv]
// Double-ended queue top level: request decode, count, response register and
// the row of deq_cell slots. Depends on deq_pkg and deq_cell.
//
//   port group  dir  payload         beat taken when
//   req_*       in   deq_req_type    req_valid && !req_stall
//   rsp_*       out  deq_rsp_type    rsp_valid && !rsp_stall
//
// Push, pop front, assign, insert and rejected requests are answered in the
// cycle after they are taken; the whole row shifts or loads at that edge, so
// insert costs no extra time. Read at a position and pop back load the lane at
// the element's cell, step it down the read lane to cell 0, then register it.
// Reset clears the count and control only; slots hold garbage until written.
// A stalled response is held in the output register; a new request is taken
// in the cycle that response leaves.
module double_ended_queue_unit import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  deq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output deq_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SEND = 3'b100
   } deq_state_type;

   deq_state_type state_ff, state_in;
   deq_cnt_type   count_ff, count_in;
   deq_idx_type   wait_ff, wait_in;
   deq_rsp_type   pend_ff, pend_in;
   deq_rsp_type   rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;

   deq_cmd_type   cmd;
   deq_elem_type  cell_data [DEPTH];
   deq_elem_type  cell_lane [DEPTH];

   logic           accept;
   logic           slot_free;
   logic           full;
   logic           empty;
   logic           in_range;
   logic           to_read;
   deq_status_type st;
   logic [31:0]    res;
   deq_cnt_type    new_count;
   deq_rsp_type    resp;
   deq_rsp_type    lane_resp;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign in_range = (32'(req_data.position) < 32'(count_ff));

   // request decode
   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.idx   = '0;
      cmd.data  = to_elem(req_data.elem_data);
      st        = ST_OK;
      res       = '0;
      new_count = count_ff;
      to_read   = 1'b0;
      if (accept) begin
         unique case (req_data.req_type)
            OP_PUSH_BACK: begin
               if (full) begin
                  st = ST_FULL;
               end else begin
                  cmd.op    = CELL_INSERT;
                  cmd.idx   = cnt_to_idx(count_ff);
                  new_count = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  st = ST_FULL;
               end else begin
                  cmd.op    = CELL_INSERT;
                  new_count = count_ff + CNT_W'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  st = ST_EMPTY;
               end else begin
                  cmd.op    = CELL_READ;
                  cmd.idx   = cnt_to_idx(count_ff - CNT_W'(1));
                  new_count = count_ff - CNT_W'(1);
                  to_read   = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  st = ST_EMPTY;
               end else begin
                  cmd.op    = CELL_REMOVE;
                  res       = from_elem(cell_data[0]);
                  new_count = count_ff - CNT_W'(1);
               end
            end
            OP_READ_AT: begin
               if (empty) begin
                  st = ST_EMPTY;
               end else if (!in_range) begin
                  st = ST_RANGE;
               end else begin
                  cmd.op  = CELL_READ;
                  cmd.idx = pos_to_idx(req_data.position);
                  to_read = 1'b1;
               end
            end
            OP_ASSIGN_AT: begin
               if (empty) begin
                  st = ST_EMPTY;
               end else if (!in_range) begin
                  st = ST_RANGE;
               end else begin
                  cmd.op  = CELL_WRITE;
                  cmd.idx = pos_to_idx(req_data.position);
               end
            end
            OP_INSERT_AT: begin
               // position at or past the end lands at the back
               if (full) begin
                  st = ST_FULL;
               end else begin
                  cmd.op    = CELL_INSERT;
                  cmd.idx   = in_range ? pos_to_idx(req_data.position)
                                       : cnt_to_idx(count_ff);
                  new_count = count_ff + CNT_W'(1);
               end
            end
            default: begin
               st = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      resp.result_data = res;
      resp.status      = st;
      resp.count       = cnt_to_field(new_count);
      resp.is_empty    = (new_count == '0);
      lane_resp             = pend_ff;
      lane_resp.result_data = from_elem(cell_lane[0]);
   end

   // control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      pend_in      = pend_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in = new_count;
               if (to_read) begin
                  pend_in  = resp;
                  wait_in  = cmd.idx;
                  state_in = S_READ;
               end else begin
                  rsp_data_in  = resp;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            if (wait_ff == '0) begin
               if (slot_free) begin
                  rsp_data_in  = lane_resp;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  // hold the element before the lane moves on
                  pend_in  = lane_resp;
                  state_in = S_SEND;
               end
            end else begin
               wait_in = wait_ff - IDX_W'(1);
            end
         end
         S_SEND: begin
            if (slot_free) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff     <= wait_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row of cells, cell 0 holds the front element
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      deq_elem_type below;
      deq_elem_type above;
      deq_elem_type above_ln;
      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_mid_lo
         assign below = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above    = '0;
         assign above_ln = '0;
      end else begin : g_mid_hi
         assign above    = cell_data[i+1];
         assign above_ln = cell_lane[i+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .below_data (below),
         .above_data (above),
         .above_lane (above_ln),
         .data_out   (cell_data[i]),
         .lane_out   (cell_lane[i])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count exceeds depth");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request taken while a read is in flight");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_FULL |-> full)
      else $error("full reported while queue has room");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.is_empty == empty)
      else $error("empty flag disagrees with count");

endmodule

[src/deq_cell.sv]
// One element slot of the queue row: holds an element and a read-lane stage.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
   input  logic         clock,
   input  deq_cmd_type  cmd,
   input  deq_idx_type  cell_index,
   input  deq_elem_type below_data,
   input  deq_elem_type above_data,
   input  deq_elem_type above_lane,
   output deq_elem_type data_out,
   output deq_elem_type lane_out
);

   deq_elem_type data_ff, data_in;
   deq_elem_type lane_ff, lane_in;
   logic         hit;
   logic         past;

   assign hit  = (cmd.idx == cell_index);
   assign past = (cell_index > cmd.idx);

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_INSERT: begin
            // open a gap: everything past the slot moves up one cell
            if (hit) begin
               data_in = cmd.data;
            end else if (past) begin
               data_in = below_data;
            end
         end
         CELL_REMOVE: begin
            data_in = above_data;
         end
         CELL_WRITE: begin
            if (hit) begin
               data_in = cmd.data;
            end
         end
         CELL_READ: begin
            data_in = data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // the lane drifts toward cell 0 one step per cycle
   assign lane_in = (cmd.op == CELL_READ && hit) ? data_ff : above_lane;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      lane_ff <= lane_in;
   end

   assign data_out = data_ff;
   assign lane_out = lane_ff;

endmodule
